@@ hw/rtl/fkq_pkg.sv @@
// shared types and constants for the fifo key queue with lookup
`default_nettype none

package fkq_pkg;

  // fixed port widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned COUNT_W = 5;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes, code 3 is a no-op
  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic push;    // successful push this cycle
    logic pop;     // successful pop this cycle, every cell takes its neighbor
    logic lookup;  // compare stored key against the search key
  } cell_ctrl_t;

endpackage : fkq_pkg

`default_nettype wire

@@ hw/rtl/fkq_cell.sv @@
// one queue cell: holds a key and its valid bit, shifts toward the head on pop
`default_nettype none

module fkq_cell
  import fkq_pkg::*;
#(
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cell_ctrl_t          ctrl_i,
  input  wire logic [KEY_BITS-1:0] key_i,
  input  wire logic                prev_valid_i,
  input  wire logic                nbr_valid_i,
  input  wire logic [KEY_BITS-1:0] nbr_key_i,
  output logic                     valid_o,
  output logic [KEY_BITS-1:0]      key_o,
  output logic                     match_o
);

  logic                valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                match_q, match_d;
  logic                load;

  // the first empty cell behind the tail takes a pushed key
  assign load = ctrl_i.push & ~valid_q & prev_valid_i;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (ctrl_i.pop) begin
      valid_d = nbr_valid_i;
      key_d   = nbr_key_i;
    end else if (load) begin
      valid_d = 1'b1;
      key_d   = key_i;
    end
  end

  // compare against the current contents, result registered
  assign match_d = ctrl_i.lookup & valid_q & (key_q == key_i);

  // valid and match state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // key payload
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign match_o = match_q;

endmodule : fkq_cell

`default_nettype wire

@@ hw/rtl/fifo_key_queue_with_lookup_unit.sv @@
// top level: bounded fifo of keys built from a chain of cells, with membership search
// results: a result strobe comes in the cycle right after the accepting edge
// throughput: one transaction per cycle, busy is never raised
// the search compares every cell in the accept cycle and or-reduces the registered hits
// reset clears all cell valid bits and the count, and sets capacity to 16
// the receiver cannot stall: every result is shown for exactly one cycle
`default_nettype none

module fifo_key_queue_with_lookup_unit
  import fkq_pkg::*;
#(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func_i,
  input  wire logic [KEY_W-1:0]   key_i,
  // result channel
  output logic                    res_valid_o,
  output logic                    ok_o,
  output logic                    full_res_o,
  output logic [COUNT_W-1:0]      count_o,
  // configuration channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CAP_W-1:0]   cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic               accept;
  logic [KEY_BITS-1:0] key_s;
  logic [CAP_W-1:0]   cap_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [W-1:0]       count_w, count_next_w, cap_eff;
  logic               push_ok, pop_ok;
  cell_ctrl_t         ctrl;

  logic [DEPTH-1:0]    valid_vec;
  logic [DEPTH-1:0]    match_vec;
  logic [KEY_BITS-1:0] key_vec [DEPTH];

  // result pipeline stage
  logic               res_valid_q;
  logic               ok_q;
  logic               lookup_q;
  logic               full_q;
  logic [COUNT_W-1:0] count_res_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // fit the key port to the stored key width
  if (KEY_BITS <= KEY_W) begin : g_key_narrow
    assign key_s = key_i[KEY_BITS-1:0];
  end else begin : g_key_wide
    assign key_s = {{(KEY_BITS - KEY_W){1'b0}}, key_i};
  end

  // effective capacity saturates at the depth
  assign cap_eff = (W'(cap_q) > W'(DEPTH)) ? W'(DEPTH) : W'(cap_q);
  assign count_w = W'(count_q);

  // operation decode
  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    if (accept) begin
      case (func_i)
        FUNC_PUSH: push_ok = (count_w < cap_eff);
        FUNC_POP:  pop_ok  = (count_q != '0);
        default:   ;
      endcase
    end
  end

  assign ctrl.push   = push_ok;
  assign ctrl.pop    = pop_ok;
  assign ctrl.lookup = accept & (func_i == FUNC_LOOKUP);

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign count_next_w = W'(count_d);

  // chain of cells, cell 0 holds the oldest entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                prev_valid;
    logic                nbr_valid;
    logic [KEY_BITS-1:0] nbr_key;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_inner
      assign prev_valid = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nbr_valid = 1'b0;
      assign nbr_key   = '0;
    end else begin : g_mid
      assign nbr_valid = valid_vec[i+1];
      assign nbr_key   = key_vec[i+1];
    end

    fkq_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_s),
      .prev_valid_i (prev_valid),
      .nbr_valid_i  (nbr_valid),
      .nbr_key_i    (nbr_key),
      .valid_o      (valid_vec[i]),
      .key_o        (key_vec[i]),
      .match_o      (match_vec[i])
    );
  end

  // count, capacity and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      res_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      lookup_q    <= 1'b0;
      full_q      <= 1'b0;
      count_res_q <= '0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        ok_q        <= push_ok | pop_ok;
        lookup_q    <= ctrl.lookup;
        full_q      <= (count_next_w >= cap_eff);
        count_res_q <= count_next_w[COUNT_W-1:0];
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign ok_o        = lookup_q ? (|match_vec) : ok_q;
  assign full_res_o  = full_q;
  assign count_o     = count_res_q;

endmodule : fifo_key_queue_with_lookup_unit

`default_nettype wire

@@ hw/rtl/fkq_checker.sv @@
// port-level checker for the fifo key queue with lookup, bound to the top level
`default_nettype none

module fkq_checker
  import fkq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [1:0]         func_i,
  input wire logic               res_valid_o,
  input wire logic               ok_o,
  input wire logic [COUNT_W-1:0] count_o
);

  // every accepted transaction gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##1 res_valid_o)
    else $error("accepted transaction produced no result");

  // no result without an earlier transaction
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ($past(start) && !$past(busy)))
    else $error("result strobe without a transaction");

  // reported count never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> ((DEPTH >= 32) || (int'(count_o) <= DEPTH)))
    else $error("count exceeds depth");

  // a successful push on back-to-back results raises the count by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && $past(res_valid_o) && ok_o && $past(func_i) == FUNC_PUSH)
      |-> (count_o == COUNT_W'($past(count_o) + COUNT_W'(1))))
    else $error("push did not advance the count");

  // a lookup on back-to-back results leaves the count unchanged
  a_lookup_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && $past(res_valid_o) && $past(func_i) == FUNC_LOOKUP)
      |-> (count_o == $past(count_o)))
    else $error("lookup changed the count");

endmodule : fkq_checker

bind fifo_key_queue_with_lookup_unit fkq_checker #(
  .DEPTH (DEPTH)
) u_fkq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .func_i      (func_i),
  .res_valid_o (res_valid_o),
  .ok_o        (ok_o),
  .count_o     (count_o)
);

`default_nettype wire
